>>> rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  // store geometry
  localparam int DEPTH  = 128;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OCC_W  = 8;

  // operation codes; the unused code behaves as a status query
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_STATUS     = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [WORD_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  data;
    logic                      data_valid;
    logic                      rejected;
    logic                      is_empty;
    logic [OCC_W-1:0]          occupancy;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/circular_double_ended_queue.sv
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// Bounded deque of signed 32-bit words kept in a circular RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation per transfer:
//   push or pop or peek at either end, or a status query. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one result per operation, in
//   order, with the popped or peeked word, a reject flag for a push into a
//   full store, and the emptiness and occupancy after the operation.
//   A result passes through the read stage, where the RAM read is registered,
//   and then through the output register.
//   Throughput: one operation per cycle while rsp_ready stays high; pointers
//   and count update at the transfer, so the next operation reads the RAM
//   with them right away.
//   Reset clears the head, tail and count and drops any pending result; the
//   RAM contents are left as they are and are never read before written.
//   When the receiver stalls, the result waits in the output register, one
//   more operation waits in the read stage, and req_ready then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_double_ended_queue
  import cdq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic             accept, advance;
  logic             full, empty;
  logic             rd_need, rej;
  logic [IDX_W-1:0] head_dn, head_up, tail_dn, tail_up;

  // read stage: result info waiting for RAM data
  logic             s1_valid;
  logic             s1_rd;
  logic             s1_rej;
  logic [CNT_W-1:0] s1_count;

  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;
  assign accept    = req_valid && req_ready;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  // circular index steps
  assign head_dn = (head == '0) ? IDX_W'(DEPTH - 1) : head - 1'b1;
  assign head_up = (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_dn = (tail == '0) ? IDX_W'(DEPTH - 1) : tail - 1'b1;
  assign tail_up = (tail == IDX_W'(DEPTH - 1)) ? '0 : tail + 1'b1;

  // operation decode, pointer update and RAM access
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ram_we     = 1'b0;
    ram_waddr  = head_dn;
    ram_raddr  = head;
    rd_need    = 1'b0;
    rej        = 1'b0;
    unique case (req.kind)
      OP_PUSH_FRONT: begin
        if (full) begin
          rej = 1'b1;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = head_dn;
          head_next  = head_dn;
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          rej = 1'b1;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = tail;
          tail_next  = tail_up;
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (!empty) begin
          rd_need   = 1'b1;
          ram_raddr = head;
          if (req.kind == OP_POP_FRONT) begin
            head_next  = head_up;
            count_next = count - 1'b1;
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (!empty) begin
          rd_need   = 1'b1;
          ram_raddr = tail_dn;
          if (req.kind == OP_POP_BACK) begin
            tail_next  = tail_dn;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    ram_we = ram_we && accept;
  end

  assign ram_re = accept && rd_need;

  cdq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(req.value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd    <= rd_need;
      s1_rej   <= rej;
      s1_count <= count_next;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.data       <= s1_rd ? ram_rdata : '0;
      rsp.data_valid <= s1_rd;
      rsp.rejected   <= s1_rej;
      rsp.is_empty   <= (s1_count == '0);
      rsp.occupancy  <= OCC_W'(s1_count);
    end
  end

endmodule

`default_nettype wire

>>> rtl/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the deque result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_checker
  import cdq_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);

  // a stalled result holds until its transfer
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // data is zero whenever it carries no word
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.data_valid |-> rsp.data == '0)
    else $error("invalid data not zero");

  // empty flag agrees with occupancy
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.is_empty == (rsp.occupancy == '0))
    else $error("empty flag and occupancy disagree");

  // a rejected push only happens on a full store and returns no word
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.rejected |->
      !rsp.data_valid && rsp.occupancy == OCC_W'(DEPTH))
    else $error("reject without a full store");

  // input is held off only while a result is stalled
  assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request stalled without a stalled result");

endmodule

bind circular_double_ended_queue cdq_checker u_cdq_checker (.*);

`default_nettype wire

>>> verif/circular_double_ended_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_double_ended_queue_test
// Self-checking bench for the circular deque: a directed opening covers the
// empty store, every operation and the extreme words. Random fill, drain and
// even mixes then run the store full and empty many times over, with random
// idling on both channels and one long result stall. Each result is checked
// field by field against an in-bench deque tracked per request transfer.
// ----------------------------------------------------------------------------

module circular_double_ended_queue_test;
  import cdq_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_OPS     = 1050;
  localparam int BLOCK_OPS      = 175;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  // spare selector code, the block treats it as a status query
  localparam logic [2:0] KIND_SPARE = 3'd7;

  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

  // --------------------------------------------------------------------------
  // in-bench deque: tracks store contents and holds the results still due
  // --------------------------------------------------------------------------
  class deque_mirror;
    logic signed [WORD_W-1:0] word_store [DEPTH];
    logic [IDX_W-1:0]         head_idx;
    logic [IDX_W-1:0]         tail_idx;
    int unsigned              word_count;
    rsp_t                     pending_results [$];
    int unsigned              mismatches;

    function new();
      head_idx   = '0;
      tail_idx   = '0;
      word_count = 0;
      mismatches = 0;
    endfunction

    function logic [IDX_W-1:0] idx_up(logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function logic [IDX_W-1:0] idx_down(logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    // apply one accepted operation and queue the result it must give
    function void note_request(req_t r);
      rsp_t             res;
      logic [IDX_W-1:0] slot;
      res = '0;
      case (r.kind)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (word_count >= DEPTH) begin
            res.rejected = 1'b1;
          end else if (r.kind == OP_PUSH_FRONT) begin
            head_idx = idx_down(head_idx);
            word_store[head_idx] = r.value;
            word_count++;
          end else begin
            word_store[tail_idx] = r.value;
            tail_idx = idx_up(tail_idx);
            word_count++;
          end
        end
        OP_POP_FRONT, OP_PEEK_FRONT: begin
          if (word_count != 0) begin
            res.data       = word_store[head_idx];
            res.data_valid = 1'b1;
            if (r.kind == OP_POP_FRONT) begin
              head_idx = idx_up(head_idx);
              word_count--;
            end
          end
        end
        OP_POP_BACK, OP_PEEK_BACK: begin
          if (word_count != 0) begin
            slot           = idx_down(tail_idx);
            res.data       = word_store[slot];
            res.data_valid = 1'b1;
            if (r.kind == OP_POP_BACK) begin
              tail_idx = slot;
              word_count--;
            end
          end
        end
        default: ;
      endcase
      res.is_empty  = (word_count == 0);
      res.occupancy = OCC_W'(word_count);
      pending_results = {pending_results, res};
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // compare one result transfer with the oldest result due
    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing outstanding: data %0h", got.data);
        mismatches++;
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      compare_field("data", want.data, got.data);
      compare_field("data_valid", WORD_W'(want.data_valid), WORD_W'(got.data_valid));
      compare_field("rejected", WORD_W'(want.rejected), WORD_W'(got.rejected));
      compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
      compare_field("occupancy", WORD_W'(want.occupancy), WORD_W'(got.occupancy));
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  deque_mirror mirror = new();

  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 45;
  int unsigned hold_asked    = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  circular_double_ended_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #CLK_HALF clk = ~clk;

  // track request transfers, then check result transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) mirror.note_request(req);
      if (rsp_valid && rsp_ready) mirror.check_result(rsp);
    end
  end

  // result side: random stalls, plus a long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // offer one operation and wait for its transfer
  task automatic send_op(input kind_t k, input logic signed [WORD_W-1:0] v);
    req_t r;
    r.kind  = k;
    r.value = v;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  // operation selector biased by the current mix
  function automatic kind_t pick_kind(op_mix_t mix);
    logic is_front;
    is_front = 1'($urandom_range(1));
    if (mix == MIX_FILL && $urandom_range(99) < 90) begin
      return is_front ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end
    if (mix == MIX_DRAIN && $urandom_range(99) < 85) begin
      return is_front ? OP_POP_FRONT : OP_POP_BACK;
    end
    return kind_t'(3'($urandom_range(7)));
  endfunction

  initial begin
    op_mix_t mix;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // empty store, spare selector, extreme words, every operation
    send_op(OP_STATUS, 32'sd0);
    send_op(OP_POP_FRONT, 32'sd5);
    send_op(OP_POP_BACK, -32'sd1);
    send_op(OP_PEEK_FRONT, 32'sd0);
    send_op(OP_PEEK_BACK, 32'sd0);
    send_op(kind_t'(KIND_SPARE), -32'sd1);
    send_op(OP_PUSH_BACK, 32'sh7fffffff);
    send_op(OP_PUSH_FRONT, 32'sh80000000);
    send_op(OP_PEEK_FRONT, 32'sd0);
    send_op(OP_PEEK_BACK, 32'sd0);
    send_op(OP_PUSH_BACK, -32'sd1);
    send_op(OP_PUSH_FRONT, 32'sd0);
    send_op(OP_STATUS, 32'sh7fffffff);
    send_op(OP_POP_BACK, 32'sd0);
    send_op(OP_POP_FRONT, 32'sd0);
    send_op(kind_t'(KIND_SPARE), 32'sd0);
    send_op(OP_POP_FRONT, 32'sd0);
    send_op(OP_POP_BACK, 32'sd0);
    send_op(OP_POP_BACK, 32'sd0);
    send_op(OP_PEEK_FRONT, 32'sd0);

    // random mixes: fill runs the store into rejects, drain empties it
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 23;
      end
      if (n == 2 * RANDOM_OPS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked <= hold_asked + 1;
      end
      case ((n / BLOCK_OPS) % 3)
        0:       mix = MIX_FILL;
        1:       mix = MIX_DRAIN;
        default: mix = MIX_EVEN;
      endcase
      send_op(pick_kind(mix), $urandom);
    end
    req_valid <= 1'b0;

    // let every due result arrive, then watch for strays
    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
